/* src/modular_coef_enumerator_assert.svh */
// Assertion macros shared by the checker of the coefficient enumerator.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef MODULAR_COEF_ENUMERATOR_ASSERT_SVH
`define MODULAR_COEF_ENUMERATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mce: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mce: next-cycle check failed");

`endif

/* src/mce_pkg.sv */
// Package for the coefficient enumerator: types, codes, register file map
// and the sequencer microprogram. No dependencies.
package mce_pkg;

    localparam int MCE_MOD_WIDTH = 24;
    localparam int MODE_W        = 2;
    localparam int IMM_W         = 9;
    localparam int RF_AW         = 5;
    localparam int PC_W          = 7;

    localparam logic [MODE_W-1:0] MODE_SET_B  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_C  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT_A = 2'd2;

    // Mode masks: bit 0 set b, bit 1 set c, bit 2 next a
    localparam logic [2:0] MSK_B   = 3'b001;
    localparam logic [2:0] MSK_C   = 3'b010;
    localparam logic [2:0] MSK_A   = 3'b100;
    localparam logic [2:0] MSK_CA  = 3'b110;
    localparam logic [2:0] MSK_ALL = 3'b111;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MULT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_END} op_t;

    typedef enum logic [1:0] {DK_REG, DK_BHALF, DK_CHALF, DK_OUT} dkind_t;

    typedef enum logic [2:0] {
        XS_REG, XS_IMM, XS_VALUE, XS_BHALF, XS_CHALF, XS_ACOUNT, XS_I2, XS_ZERO
    } xsel_t;

    typedef enum logic [1:0] {YS_REG, YS_ONE, YS_ZERO} ysel_t;

    typedef struct packed {
        op_t               op;
        dkind_t            dk;
        logic [RF_AW-1:0]  d;
        xsel_t             xs;
        logic [RF_AW-1:0]  xr;
        ysel_t             ys;
        logic [RF_AW-1:0]  yr;
        logic [IMM_W-1:0]  imm;
        logic [2:0]        mask;
    } instr_t;

    // Register file map
    localparam logic [RF_AW-1:0] R_I2   = 5'd0;
    localparam logic [RF_AW-1:0] R_B    = 5'd1;
    localparam logic [RF_AW-1:0] R_C    = 5'd2;
    localparam logic [RF_AW-1:0] R_B2   = 5'd3;
    localparam logic [RF_AW-1:0] R_B3   = 5'd4;
    localparam logic [RF_AW-1:0] R_B4   = 5'd5;
    localparam logic [RF_AW-1:0] R_CB   = 5'd6;
    localparam logic [RF_AW-1:0] R_I4   = 5'd7;
    localparam logic [RF_AW-1:0] R_I8   = 5'd8;
    localparam logic [RF_AW-1:0] R_T    = 5'd9;
    localparam logic [RF_AW-1:0] R_U    = 5'd10;
    localparam logic [RF_AW-1:0] R_S    = 5'd11;
    localparam logic [RF_AW-1:0] R_K0   = 5'd12;
    localparam logic [RF_AW-1:0] R_A    = 5'd13;
    localparam logic [RF_AW-1:0] R_I88  = 5'd14;
    localparam logic [RF_AW-1:0] R_I2B2 = 5'd15;
    localparam logic [RF_AW-1:0] R_I2B3 = 5'd16;
    localparam logic [RF_AW-1:0] R_I4B  = 5'd17;
    localparam logic [RF_AW-1:0] R_I4C  = 5'd18;
    localparam logic [RF_AW-1:0] R_I8B  = 5'd19;
    localparam logic [RF_AW-1:0] R_I8B2 = 5'd20;
    localparam logic [RF_AW-1:0] R_H    = 5'd21;

    // Output slots coef3..coef7
    localparam logic [RF_AW-1:0] O_C3 = 5'd0;
    localparam logic [RF_AW-1:0] O_C4 = 5'd1;
    localparam logic [RF_AW-1:0] O_C5 = 5'd2;
    localparam logic [RF_AW-1:0] O_C6 = 5'd3;
    localparam logic [RF_AW-1:0] O_C7 = 5'd4;

    function automatic instr_t f_mk(op_t op, dkind_t dk, logic [RF_AW-1:0] d,
                                    xsel_t xs, logic [RF_AW-1:0] xr,
                                    ysel_t ys, logic [RF_AW-1:0] yr,
                                    logic [IMM_W-1:0] imm, logic [2:0] m);
        instr_t r;
        r.op   = op;
        r.dk   = dk;
        r.d    = d;
        r.xs   = xs;
        r.xr   = xr;
        r.ys   = ys;
        r.yr   = yr;
        r.imm  = imm;
        r.mask = m;
        return r;
    endfunction

    function automatic instr_t f_mulr(logic [RF_AW-1:0] d, logic [RF_AW-1:0] x,
                                      logic [RF_AW-1:0] y, logic [2:0] m);
        return f_mk(OP_MUL, DK_REG, d, XS_REG, x, YS_REG, y, '0, m);
    endfunction

    function automatic instr_t f_muli(logic [RF_AW-1:0] d, logic [IMM_W-1:0] k,
                                      logic [RF_AW-1:0] y);
        return f_mk(OP_MUL, DK_REG, d, XS_IMM, R_I2, YS_REG, y, k, MSK_A);
    endfunction

    function automatic instr_t f_alu(op_t op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] x,
                                     logic [RF_AW-1:0] y, logic [2:0] m);
        return f_mk(op, DK_REG, d, XS_REG, x, YS_REG, y, '0, m);
    endfunction

    function automatic instr_t f_end(logic [2:0] m);
        return f_mk(OP_END, DK_REG, R_I2, XS_ZERO, R_I2, YS_ZERO, R_I2, '0, m);
    endfunction

    // h = h * a, the Horner step
    function automatic instr_t f_ha();
        return f_mulr(R_H, R_H, R_A, MSK_A);
    endfunction

    // Microprogram; polynomials in a are evaluated by Horner's rule
    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            7'd0:   r = f_mk(OP_MUL, DK_REG, R_I2, XS_I2, R_I2, YS_ONE, R_I2, '0, MSK_ALL);
            7'd1:   r = f_mk(OP_MUL, DK_BHALF, R_I2, XS_VALUE, R_I2, YS_REG, R_I2, '0, MSK_B);
            7'd2:   r = f_end(MSK_B);
            7'd3:   r = f_mk(OP_MUL, DK_CHALF, R_I2, XS_VALUE, R_I2, YS_REG, R_I2, '0, MSK_C);
            7'd4:   r = f_mk(OP_MUL, DK_REG, R_B, XS_BHALF, R_I2, YS_ONE, R_I2, '0, MSK_CA);
            7'd5:   r = f_mk(OP_MUL, DK_REG, R_C, XS_CHALF, R_I2, YS_ONE, R_I2, '0, MSK_CA);
            7'd6:   r = f_mulr(R_B2, R_B, R_B, MSK_CA);
            7'd7:   r = f_mulr(R_B3, R_B2, R_B, MSK_CA);
            7'd8:   r = f_mulr(R_B4, R_B2, R_B2, MSK_CA);
            7'd9:   r = f_mulr(R_CB, R_C, R_B, MSK_CA);
            7'd10:  r = f_mulr(R_I4, R_I2, R_I2, MSK_CA);
            7'd11:  r = f_mulr(R_I8, R_I2, R_I4, MSK_CA);
            7'd12:  r = f_mulr(R_T, R_I4, R_B4, MSK_CA);
            7'd13:  r = f_mulr(R_U, R_C, R_B2, MSK_CA);
            7'd14:  r = f_alu(OP_SUB, R_S, R_T, R_U, MSK_CA);
            7'd15:  r = f_mulr(R_U, R_C, R_C, MSK_CA);
            7'd16:  r = f_alu(OP_ADD, R_S, R_S, R_U, MSK_CA);
            7'd17:  r = f_alu(OP_ADD, R_K0, R_CB, R_CB, MSK_CA);
            7'd18:  r = f_alu(OP_SUB, R_K0, R_K0, R_B3, MSK_CA);
            7'd19:  r = f_mk(OP_ADD, DK_OUT, O_C3, XS_REG, R_K0, YS_ZERO, R_I2, '0, MSK_C);
            7'd20:  r = f_mk(OP_ADD, DK_OUT, O_C4, XS_REG, R_S, YS_ZERO, R_I2, '0, MSK_C);
            7'd21:  r = f_end(MSK_C);
            7'd22:  r = f_mk(OP_MUL, DK_REG, R_A, XS_ACOUNT, R_I2, YS_ONE, R_I2, '0, MSK_A);
            7'd23:  r = f_mulr(R_I88, R_I8, R_I8, MSK_A);
            7'd24:  r = f_mulr(R_I2B2, R_I2, R_B2, MSK_A);
            7'd25:  r = f_mulr(R_I2B3, R_I2, R_B3, MSK_A);
            7'd26:  r = f_mulr(R_I4B, R_I4, R_B, MSK_A);
            7'd27:  r = f_mulr(R_I4C, R_I4, R_C, MSK_A);
            7'd28:  r = f_mulr(R_I8B, R_I8, R_B, MSK_A);
            7'd29:  r = f_mulr(R_I8B2, R_I8, R_B2, MSK_A);
            // coef3
            7'd30:  r = f_muli(R_H, 9'd35, R_I8);
            7'd31:  r = f_ha();
            7'd32:  r = f_muli(R_T, 9'd15, R_I4B);
            7'd33:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd34:  r = f_ha();
            7'd35:  r = f_muli(R_T, 9'd3, R_C);
            7'd36:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd37:  r = f_muli(R_T, 9'd3, R_I2B2);
            7'd38:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd39:  r = f_ha();
            7'd40:  r = f_mk(OP_ADD, DK_OUT, O_C3, XS_REG, R_H, YS_REG, R_K0, '0, MSK_A);
            // coef4
            7'd41:  r = f_muli(R_H, 9'd105, R_I88);
            7'd42:  r = f_ha();
            7'd43:  r = f_muli(R_T, 9'd25, R_I8B);
            7'd44:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd45:  r = f_ha();
            7'd46:  r = f_muli(R_T, 9'd3, R_I4C);
            7'd47:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd48:  r = f_muli(R_T, 9'd33, R_I8B2);
            7'd49:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd50:  r = f_ha();
            7'd51:  r = f_muli(R_T, 9'd3, R_CB);
            7'd52:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd53:  r = f_muli(R_T, 9'd3, R_I2B3);
            7'd54:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd55:  r = f_ha();
            7'd56:  r = f_mk(OP_ADD, DK_OUT, O_C4, XS_REG, R_H, YS_REG, R_S, '0, MSK_A);
            // coef5
            7'd57:  r = f_muli(R_T, 9'd21, R_I88);
            7'd58:  r = f_mk(OP_SUB, DK_REG, R_H, XS_ZERO, R_I2, YS_REG, R_T, '0, MSK_A);
            7'd59:  r = f_ha();
            7'd60:  r = f_muli(R_T, 9'd15, R_I8B);
            7'd61:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd62:  r = f_ha();
            7'd63:  r = f_muli(R_T, 9'd17, R_I4C);
            7'd64:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd65:  r = f_muli(R_T, 9'd27, R_I8B2);
            7'd66:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd67:  r = f_ha();
            7'd68:  r = f_muli(R_T, 9'd3, R_I2B3);
            7'd69:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd70:  r = f_muli(R_T, 9'd3, R_CB);
            7'd71:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd72:  r = f_ha();
            7'd73:  r = f_muli(R_T, 9'd3, R_S);
            7'd74:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd75:  r = f_ha();
            7'd76:  r = f_mk(OP_ADD, DK_OUT, O_C5, XS_REG, R_H, YS_ZERO, R_I2, '0, MSK_A);
            // coef6
            7'd77:  r = f_muli(R_H, 9'd315, R_I88);
            7'd78:  r = f_ha();
            7'd79:  r = f_muli(R_T, 9'd69, R_I8B);
            7'd80:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd81:  r = f_ha();
            7'd82:  r = f_muli(R_T, 9'd33, R_I4C);
            7'd83:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd84:  r = f_muli(R_T, 9'd3, R_I8B2);
            7'd85:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd86:  r = f_ha();
            7'd87:  r = f_muli(R_T, 9'd7, R_I2B3);
            7'd88:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd89:  r = f_muli(R_T, 9'd7, R_CB);
            7'd90:  r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd91:  r = f_ha();
            7'd92:  r = f_muli(R_T, 9'd3, R_S);
            7'd93:  r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd94:  r = f_ha();
            7'd95:  r = f_ha();
            7'd96:  r = f_mk(OP_ADD, DK_OUT, O_C6, XS_REG, R_H, YS_ZERO, R_I2, '0, MSK_A);
            // coef7
            7'd97:  r = f_muli(R_H, 9'd225, R_I88);
            7'd98:  r = f_ha();
            7'd99:  r = f_muli(R_T, 9'd45, R_I8B);
            7'd100: r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd101: r = f_ha();
            7'd102: r = f_muli(R_T, 9'd3, R_I8B2);
            7'd103: r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd104: r = f_muli(R_T, 9'd15, R_I4C);
            7'd105: r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd106: r = f_ha();
            7'd107: r = f_muli(R_T, 9'd3, R_I2B3);
            7'd108: r = f_alu(OP_ADD, R_H, R_H, R_T, MSK_A);
            7'd109: r = f_muli(R_T, 9'd3, R_CB);
            7'd110: r = f_alu(OP_SUB, R_H, R_H, R_T, MSK_A);
            7'd111: r = f_ha();
            7'd112: r = f_alu(OP_ADD, R_H, R_H, R_S, MSK_A);
            7'd113: r = f_ha();
            7'd114: r = f_ha();
            7'd115: r = f_ha();
            7'd116: r = f_mk(OP_ADD, DK_OUT, O_C7, XS_REG, R_H, YS_ZERO, R_I2, '0, MSK_A);
            default: r = f_end(MSK_ALL);
        endcase
        return r;
    endfunction

endpackage

/* src/modular_coef_enumerator.sv */
// Top level of the coefficient enumerator: stream ports, sequencer and a
// bit-serial modular multiplier. Depends on mce_pkg.
//
// Usage: write the odd prime p through cfg_wr_en/cfg_wr_data while idle
// (reset value 3; a write of zero acts as 1). Each input item carries a
// mode in s_tuser and a value in s_tdata: mode 0 stores b = value/2,
// mode 1 stores c = value/2, restarts the counter a and returns the base
// coefficients, mode 2 steps a and returns coef3..coef7 as residues mod p,
// or m_tuser = 0 with zero coefficients once a has reached p. Every item
// gives exactly one result item. All products run on one shared modular
// multiplier that consumes one multiplier bit per cycle; adds and
// subtracts use a combinational modular ALU, both under the microprogram
// sequencer. At MOD_WIDTH 24 a mode 2 item takes 75 products, and a
// finished enumeration or mode 3 skips the microprogram. One item is
// worked on at a time; a new item is taken as soon as the previous
// result sits in the output register, even if that result has not yet
// been taken.
module modular_coef_enumerator #(
    parameter int MOD_WIDTH = mce_pkg::MCE_MOD_WIDTH,
    localparam int IN_DW  = ((MOD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((6 * MOD_WIDTH + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_DW-1:0]            s_tdata,    // value, zero pad
    input  logic [mce_pkg::MODE_W-1:0]  s_tuser,    // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_DW-1:0]           m_tdata,    // coef3..coef7, a_now, zero pad
    output logic [0:0]                  m_tuser,    // more
    input  logic                        cfg_wr_en,
    input  logic [MOD_WIDTH-1:0]        cfg_wr_data
);

    localparam int W  = MOD_WIDTH;
    localparam int XW = (MOD_WIDTH > mce_pkg::IMM_W) ? MOD_WIDTH : mce_pkg::IMM_W;
    localparam int CW = $clog2(XW + 1);

    mce_pkg::state_t state_reg, state_next;

    logic [mce_pkg::PC_W-1:0]   pc_reg;
    logic [mce_pkg::MODE_W-1:0] mode_reg;
    logic [W-1:0]               modulus_reg;   // effective modulus, never zero
    logic [W-1:0]               b_half_reg, c_half_reg, a_count_reg;
    logic [W-1:0]               value_reg;
    logic                       more_reg;
    logic [W-1:0]               co_reg [5];

    // multiplier
    logic [W-1:0]  acc_reg, y_reg;
    logic [XW-1:0] x_sh_reg;
    logic [CW-1:0] cnt_reg;

    // register file, two registered read ports
    logic [W-1:0] rf [2**mce_pkg::RF_AW];
    logic [W-1:0] rdx_reg, rdy_reg;

    logic                m_tvalid_reg;
    logic [OUT_DW-1:0]   m_tdata_reg;
    logic                m_tuser_reg;

    mce_pkg::instr_t instr;
    logic            mode_hit;
    logic            accept;
    logic            out_load;
    logic            wr_en;
    logic [W-1:0]    wr_val;
    logic [W-1:0]    i2_val, one_val;
    logic [XW-1:0]   x_load;
    logic [W-1:0]    y_load, x_alu;
    logic [W:0]      alu_sum, alu_diff, alu_res;
    logic [W:0]      acc_dbl, acc_red, acc_sum, acc_new;
    logic [W-1:0]    a_inc;
    logic            a_live;

    assign instr = mce_pkg::prog(pc_reg);

    assign mode_hit = ((mode_reg == mce_pkg::MODE_SET_B)  && instr.mask[0])
                   || ((mode_reg == mce_pkg::MODE_SET_C)  && instr.mask[1])
                   || ((mode_reg == mce_pkg::MODE_NEXT_A) && instr.mask[2]);

    // constants derived from p: 2^-1 = (p+1)/2, and 1 mod p
    assign i2_val  = (modulus_reg == W'(1)) ? '0 : (modulus_reg >> 1) + W'(modulus_reg[0]);
    assign one_val = (modulus_reg == W'(1)) ? '0 : W'(1);

    // counter step taken on a mode 2 item
    assign a_inc  = (a_count_reg < modulus_reg) ? a_count_reg + W'(1) : a_count_reg;
    assign a_live = a_inc < modulus_reg;

    always_comb
    begin
        case (instr.xs)
            mce_pkg::XS_REG:    x_load = XW'(rdx_reg);
            mce_pkg::XS_IMM:    x_load = XW'(instr.imm);
            mce_pkg::XS_VALUE:  x_load = XW'(value_reg);
            mce_pkg::XS_BHALF:  x_load = XW'(b_half_reg);
            mce_pkg::XS_CHALF:  x_load = XW'(c_half_reg);
            mce_pkg::XS_ACOUNT: x_load = XW'(a_count_reg);
            mce_pkg::XS_I2:     x_load = XW'(i2_val);
            default:            x_load = '0;
        endcase
        case (instr.ys)
            mce_pkg::YS_REG: y_load = rdy_reg;
            mce_pkg::YS_ONE: y_load = one_val;
            default:         y_load = '0;
        endcase
        x_alu = (instr.xs == mce_pkg::XS_ZERO) ? '0 : rdx_reg;
    end

    // combinational modular add / subtract on residues
    always_comb
    begin
        alu_sum  = {1'b0, x_alu} + {1'b0, y_load};
        alu_diff = {1'b0, x_alu} - {1'b0, y_load};
        if (instr.op == mce_pkg::OP_SUB)
            alu_res = (x_alu < y_load) ? alu_diff + {1'b0, modulus_reg} : alu_diff;
        else
            alu_res = (alu_sum >= {1'b0, modulus_reg}) ? alu_sum - {1'b0, modulus_reg}
                                                       : alu_sum;
    end

    // multiplier step, MSB first: acc = 2*acc + bit*y, both reduced mod p
    always_comb
    begin
        acc_dbl = {acc_reg, 1'b0};
        acc_red = (acc_dbl >= {1'b0, modulus_reg}) ? acc_dbl - {1'b0, modulus_reg} : acc_dbl;
        acc_sum = acc_red + (x_sh_reg[XW-1] ? {1'b0, y_reg} : '0);
        acc_new = (acc_sum >= {1'b0, modulus_reg}) ? acc_sum - {1'b0, modulus_reg} : acc_sum;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        wr_val     = alu_res[W-1:0];
        s_tready   = 1'b0;
        case (state_reg)
            mce_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    accept = 1'b1;
                    if (s_tuser == mce_pkg::MODE_SET_B || s_tuser == mce_pkg::MODE_SET_C
                        || (s_tuser == mce_pkg::MODE_NEXT_A && a_live))
                        state_next = mce_pkg::ST_FETCH;
                    else
                        state_next = mce_pkg::ST_DONE;
                end
            end
            mce_pkg::ST_FETCH:
            begin
                if (mode_hit && instr.op == mce_pkg::OP_END)
                    state_next = mce_pkg::ST_DONE;
                else if (mode_hit)
                    state_next = mce_pkg::ST_LOAD;
            end
            mce_pkg::ST_LOAD:
            begin
                if (instr.op == mce_pkg::OP_MUL)
                    state_next = mce_pkg::ST_MULT;
                else
                begin
                    wr_en      = 1'b1;
                    state_next = mce_pkg::ST_FETCH;
                end
            end
            mce_pkg::ST_MULT:
            begin
                wr_val = acc_new[W-1:0];
                if (cnt_reg == CW'(1))
                begin
                    wr_en      = 1'b1;
                    state_next = mce_pkg::ST_FETCH;
                end
            end
            mce_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mce_pkg::ST_IDLE;
                end
            end
            default: state_next = mce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mce_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            mode_reg     <= mce_pkg::MODE_SET_B;
            modulus_reg  <= W'(3);
            b_half_reg   <= '0;
            c_half_reg   <= '0;
            a_count_reg  <= '0;
            more_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                modulus_reg <= (cfg_wr_data == '0) ? W'(1) : cfg_wr_data;
            if (accept)
            begin
                pc_reg   <= '0;
                mode_reg <= s_tuser;
                more_reg <= 1'b1;
                if (s_tuser == mce_pkg::MODE_SET_C)
                    a_count_reg <= '0;
                else if (s_tuser == mce_pkg::MODE_NEXT_A)
                begin
                    a_count_reg <= a_inc;
                    more_reg    <= a_live;
                end
            end
            if ((state_reg == mce_pkg::ST_FETCH && !mode_hit) || wr_en)
                pc_reg <= pc_reg + mce_pkg::PC_W'(1);
            if (wr_en && instr.dk == mce_pkg::DK_BHALF)
                b_half_reg <= wr_val;
            if (wr_en && instr.dk == mce_pkg::DK_CHALF)
                c_half_reg <= wr_val;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= s_tdata[W-1:0];
            for (int i = 0; i < 5; i++)
                co_reg[i] <= '0;
        end
        if (wr_en && instr.dk == mce_pkg::DK_OUT)
            co_reg[instr.d[2:0]] <= wr_val;
        if (state_reg == mce_pkg::ST_LOAD)
        begin
            acc_reg  <= '0;
            x_sh_reg <= x_load;
            y_reg    <= y_load;
            cnt_reg  <= CW'(XW);
        end
        else if (state_reg == mce_pkg::ST_MULT)
        begin
            acc_reg  <= acc_new[W-1:0];
            x_sh_reg <= {x_sh_reg[XW-2:0], 1'b0};
            cnt_reg  <= cnt_reg - CW'(1);
        end
        if (out_load)
        begin
            m_tdata_reg <= OUT_DW'({a_count_reg, co_reg[4], co_reg[3], co_reg[2],
                                    co_reg[1], co_reg[0]});
            m_tuser_reg <= more_reg;
        end
    end

    // register file
    always_ff @(posedge clk)
    begin
        if (wr_en && instr.dk == mce_pkg::DK_REG)
            rf[instr.d] <= wr_val;
        rdx_reg <= rf[instr.xr];
        rdy_reg <= rf[instr.yr];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

/* src/mce_checker.sv */
// Port-level checker for the coefficient enumerator, bound to the top level.
// Depends on mce_pkg and modular_coef_enumerator_assert.svh.
`include "modular_coef_enumerator_assert.svh"

module mce_checker #(
    parameter int MOD_WIDTH = mce_pkg::MCE_MOD_WIDTH,
    localparam int IN_DW  = ((MOD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((6 * MOD_WIDTH + 7) / 8) * 8
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [IN_DW-1:0]            s_tdata,
    input logic [mce_pkg::MODE_W-1:0]  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [OUT_DW-1:0]           m_tdata,
    input logic [0:0]                  m_tuser,
    input logic                        cfg_wr_en,
    input logic [MOD_WIDTH-1:0]        cfg_wr_data
);

    // a stalled result item holds
    `MCE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a finished enumeration reports zero coefficients
    `MCE_ASSERT_SAME(a_done_zero, m_tvalid && !m_tuser[0], m_tdata[5*MOD_WIDTH-1:0] == '0)

    // one item at a time: busy right after an accept
    `MCE_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule

bind modular_coef_enumerator mce_checker #(.MOD_WIDTH(MOD_WIDTH)) u_mce_checker (.*);

/* bench/tb_modular_coef_enumerator.sv */
// Self-checking bench for the modular coefficient enumerator.
// Depends on mce_pkg and modular_coef_enumerator; needs nothing else.
module tb_modular_coef_enumerator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 24;
    typedef logic [mce_pkg::MODE_W-1:0] mode_t;
    localparam mode_t MODE_NONE = 2'd3;               // ignored mode
    localparam int STALL_LIMIT = 40000;               // cycles with no handshake
    localparam logic [W-1:0] BIG_PRIME = 24'd16777213;

    typedef struct packed {
        mode_t        mode;
        logic [W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [4:0][W-1:0] coef;   // coef3 in slot 0
        logic [W-1:0]      a_now;
        logic              more;
    } coefs_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [W-1:0] s_tdata = '0;
    mode_t s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [W-1:0] cfg_wr_data = '0;

    modular_coef_enumerator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial forever #1 clk = ~clk;

    // Pending items, expected coefficient sets, run control
    cmd_t   cmd_q[$];
    coefs_t coef_q[$];
    cmd_t   cur_cmd;
    int     send_idle = 0;
    int     recv_idle = 0;
    bit     hold = 1'b1;
    int     n_bad = 0;
    int     n_stall = 0;

    // Shadow of the block's state
    longint unsigned p_reg = 3;
    longint unsigned pm;
    longint unsigned b_st = 0, c_st = 0, a_st = 0;

    function automatic longint unsigned rd(longint unsigned x);
        return x % pm;
    endfunction
    function automatic longint unsigned mm(longint unsigned x, longint unsigned y);
        return (rd(x) * rd(y)) % pm;
    endfunction
    function automatic longint unsigned ma(longint unsigned x, longint unsigned y);
        return (rd(x) + rd(y)) % pm;
    endfunction
    function automatic longint unsigned mn(longint unsigned x);
        return (pm - rd(x)) % pm;
    endfunction
    function automatic longint unsigned ms(longint unsigned x, longint unsigned y);
        return ma(x, mn(y));
    endfunction

    // sum of k[e] * a^e
    function automatic longint unsigned horner(longint unsigned k[8], longint unsigned a);
        longint unsigned acc;
        acc = 0;
        for (int e = 7; e >= 0; e--)
            acc = ma(mm(acc, a), k[e]);
        return acc;
    endfunction

    // Advance the shadow state by one item and return its coefficient set
    task automatic step_enum(input cmd_t c, output coefs_t r);
        longint unsigned i2, i4, i8, i88, b, cc, b2, b3, b4, cb, s, k0;
        longint unsigned k[8];
        pm  = (p_reg == 0) ? 1 : p_reg;
        i2  = rd((pm + 1) / 2);
        i4  = mm(i2, i2);
        i8  = mm(i2, i4);
        r   = '0;
        r.more = 1'b1;
        if (c.mode == mce_pkg::MODE_SET_B)
            b_st = mm(c.value, i2);
        else if (c.mode == mce_pkg::MODE_SET_C)
        begin
            c_st = mm(c.value, i2);
            a_st = 0;
        end
        b   = rd(b_st);
        cc  = rd(c_st);
        b2  = mm(b, b);
        b3  = mm(b2, b);
        b4  = mm(b2, b2);
        cb  = mm(cc, b);
        s   = ma(ms(mm(i4, b4), mm(cc, b2)), mm(cc, cc));
        i88 = mm(i8, i8);
        k0  = ma(mn(b3), mm(2, cb));
        if (c.mode == mce_pkg::MODE_SET_C)
        begin
            r.coef[0] = k0;
            r.coef[1] = s;
        end
        else if (c.mode == mce_pkg::MODE_NEXT_A)
        begin
            if (a_st < pm)
                a_st++;
            if (a_st >= pm)
                r.more = 1'b0;
            else
            begin
                k = '{default: 0};
                k[3] = mm(35, i8);
                k[2] = mn(mm(15, mm(i4, b)));
                k[1] = ms(mm(3, cc), mm(3, mm(i2, b2)));
                k[0] = k0;
                r.coef[0] = horner(k, a_st);
                k = '{default: 0};
                k[4] = mm(105, i88);
                k[3] = mm(25, mm(i8, b));
                k[2] = ms(mm(3, mm(i4, cc)), mm(33, mm(i8, b2)));
                k[1] = ms(mm(3, cb), mm(3, mm(i2, b3)));
                k[0] = s;
                r.coef[1] = horner(k, a_st);
                k = '{default: 0};
                k[5] = mn(mm(21, i88));
                k[4] = mm(15, mm(i8, b));
                k[3] = ms(mm(17, mm(i4, cc)), mm(27, mm(i8, b2)));
                k[2] = ms(mm(3, mm(i2, b3)), mm(3, cb));
                k[1] = mm(3, s);
                r.coef[2] = horner(k, a_st);
                k = '{default: 0};
                k[6] = mm(315, i88);
                k[5] = mn(mm(69, mm(i8, b)));
                k[4] = ms(mm(33, mm(i4, cc)), mm(3, mm(i8, b2)));
                k[3] = ms(mm(7, mm(i2, b3)), mm(7, cb));
                k[2] = mm(3, s);
                r.coef[3] = horner(k, a_st);
                k = '{default: 0};
                k[7] = mm(225, i88);
                k[6] = mn(mm(45, mm(i8, b)));
                k[5] = ma(mm(3, mm(i8, b2)), mm(15, mm(i4, cc)));
                k[4] = ms(mm(3, mm(i2, b3)), mm(3, cb));
                k[3] = s;
                r.coef[4] = horner(k, a_st);
            end
        end
        r.a_now = a_st[W-1:0];
    endtask

    // Driver: predict on acceptance, then present the next pending item
    always @(posedge clk)
    begin
        coefs_t exp_set;
        cmd_t   nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                step_enum(cur_cmd, exp_set);
                coef_q.push_back(exp_set);
            end
            if (!s_tvalid || s_tready)
            begin
                if (!hold && cmd_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = cmd_q.pop_front();
                    cur_cmd  <= nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= nxt.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        coefs_t got, want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (m_tvalid && m_tready)
            begin
                got.coef  = m_tdata[5*W-1:0];
                got.a_now = m_tdata[6*W-1:5*W];
                got.more  = m_tuser[0];
                if (coef_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result item %h more=%0d", m_tdata, m_tuser);
                end
                else
                begin
                    want = coef_q.pop_front();
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"mismatch: exp c3..c7 %h a=%0d more=%0d, ",
                                      "got %h a=%0d more=%0d"},
                                     want.coef, want.a_now, want.more,
                                     got.coef, got.a_now, got.more);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            n_stall <= 0;
        else
            n_stall <= n_stall + 1;
        if (n_stall >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Let the pending items go, wait until all results are in, then pause
    // the sender and let the block settle
    task automatic drain();
        hold = 1'b0;
        @(negedge clk);
        while (cmd_q.size() != 0 || s_tvalid || coef_q.size() != 0)
            @(negedge clk);
        hold = 1'b1;
        repeat (50) @(posedge clk);
    endtask

    task automatic set_modulus(input logic [W-1:0] p);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        p_reg = p;
    endtask

    task automatic push(input mode_t m, input logic [W-1:0] v);
        cmd_t c;
        c.mode  = m;
        c.value = v;
        cmd_q.push_back(c);
    endtask

    // Random value: mostly below p, sometimes any 24-bit pattern
    function automatic logic [W-1:0] rnd_val(longint unsigned p);
        if (p > 1 && $urandom_range(9) != 0)
            return W'($urandom % p);
        return W'($urandom);
    endfunction

    initial
    begin
        longint unsigned p;
        int n_rand, n_ma;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset modulus 3: step at reset, ignored mode, run to the end
        push(mce_pkg::MODE_NEXT_A, 24'd0);
        push(MODE_NONE, 24'hFFFFFF);
        push(mce_pkg::MODE_SET_B, 24'd2);
        push(mce_pkg::MODE_SET_C, 24'd1);
        repeat (4) push(mce_pkg::MODE_NEXT_A, 24'd0);
        hold = 1'b0;

        // Largest prime: values above p and zero
        set_modulus(BIG_PRIME);
        push(mce_pkg::MODE_SET_B, 24'hFFFFFE);
        push(mce_pkg::MODE_SET_C, 24'hFFFFFF);
        repeat (3) push(mce_pkg::MODE_NEXT_A, 24'hFFFFFF);
        push(mce_pkg::MODE_SET_B, 24'd0);
        push(mce_pkg::MODE_SET_C, 24'd0);
        repeat (3) push(mce_pkg::MODE_NEXT_A, 24'd0);
        hold = 1'b0;

        // Counter already at a smaller new modulus, stored b, c reduced
        set_modulus(24'd3);
        push(mce_pkg::MODE_NEXT_A, 24'd0);
        push(mce_pkg::MODE_SET_C, 24'd5);
        hold = 1'b0;

        // Modulus zero, then an all-ones non-prime, then an even one
        set_modulus(24'd0);
        push(mce_pkg::MODE_SET_B, 24'd5);
        push(mce_pkg::MODE_SET_C, 24'd7);
        push(mce_pkg::MODE_NEXT_A, 24'd0);
        hold = 1'b0;
        set_modulus(24'hFFFFFF);
        push(mce_pkg::MODE_SET_B, 24'h123456);
        push(mce_pkg::MODE_SET_C, 24'hABCDEF);
        push(mce_pkg::MODE_NEXT_A, 24'd0);
        hold = 1'b0;
        set_modulus(24'd4);
        push(mce_pkg::MODE_SET_C, 24'd3);
        repeat (2) push(mce_pkg::MODE_NEXT_A, 24'd0);
        hold = 1'b0;

        // Random phases: well-formed runs (b, c, steps) with some noise
        n_rand = 0;
        while (n_rand < 1250)
        begin
            case ($urandom_range(9))
                0: p = 3;
                1: p = 5;
                2: p = 7;
                3: p = 13;
                4: p = 31;
                5: p = 257;
                6: p = 65521;
                7: p = BIG_PRIME;
                8: p = 24'hFFFFFF;
                default: p = longint'($urandom & 32'hFFFFFF) | 1;
            endcase
            set_modulus(W'(p));
            if (n_rand < 420)
            begin
                send_idle = 22;
                recv_idle = 88;
            end
            else if (n_rand < 840)
            begin
                send_idle = 88;
                recv_idle = 22;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int run = 0; run < 4; run++)
            begin
                if ($urandom_range(9) == 0)
                    push(MODE_NONE, W'($urandom));
                if ($urandom_range(3) != 0)
                    push(mce_pkg::MODE_SET_B, rnd_val(p));
                push(mce_pkg::MODE_SET_C, rnd_val(p));
                n_ma = (p < 40) ? $urandom_range(int'(p) + 1) : $urandom_range(6, 1);
                repeat (n_ma)
                begin
                    if ($urandom_range(19) == 0)
                        push(mode_t'($urandom_range(3)), W'($urandom));
                    push(mce_pkg::MODE_NEXT_A, W'($urandom));
                end
                n_rand += n_ma + 2;
            end
            hold = 1'b0;
        end

        drain();
        if (n_bad == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* modular_coef_enumerator.f */
+incdir+src
src/mce_pkg.sv
src/modular_coef_enumerator.sv
src/mce_checker.sv
bench/tb_modular_coef_enumerator.sv
